### rtl/core/sdfr_pkg.sv
// Shared types and constants of the spatial derivative filter.
`default_nettype none

package sdfr_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int LEN_W    = 9;
    localparam int OUT_W    = 20;
    localparam int POS_W    = 8;

    // Internal arithmetic widths
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = COEF_W + DIFF_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 15;
    localparam int NEG_W    = OUT_W + 1;
    localparam int MAG_W    = OUT_W + 2;
    localparam int RECT_W   = OUT_W + 3;

    // Filter geometry
    localparam int WIN_DEPTH  = 8;
    localparam int HALF_TAPS  = 4;
    localparam int CALC_FIRST = 2 * HALF_TAPS;
    localparam int MAX_RUN    = HALF_TAPS + 1;
    localparam int CNT_W      = 3;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [PADDR_W-3:0] {
        REG_FRAME_SIZE,
        REG_COEF_INNER,
        REG_COEF_SECOND,
        REG_COEF_THIRD,
        REG_COEF_OUTER
    } t_reg_idx;

    localparam logic [LEN_W-1:0]         FRAME_SIZE_RST  = 9'd188;
    localparam logic signed [COEF_W-1:0] COEF_INNER_RST  = 16'sd18078;
    localparam logic signed [COEF_W-1:0] COEF_SECOND_RST = 16'sd9041;
    localparam logic signed [COEF_W-1:0] COEF_THIRD_RST  = 16'sd4519;
    localparam logic signed [COEF_W-1:0] COEF_OUTER_RST  = 16'sd1130;

    typedef struct packed {
        logic [LEN_W-1:0]         frame_size;
        logic signed [COEF_W-1:0] coef_inner;
        logic signed [COEF_W-1:0] coef_second;
        logic signed [COEF_W-1:0] coef_third;
        logic signed [COEF_W-1:0] coef_outer;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/core/sdfr_regs.sv
// Configuration register file of the spatial derivative filter.
`default_nettype none

module sdfr_regs
    import sdfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_size  <= FRAME_SIZE_RST;
            r_cfg.coef_inner  <= COEF_INNER_RST;
            r_cfg.coef_second <= COEF_SECOND_RST;
            r_cfg.coef_third  <= COEF_THIRD_RST;
            r_cfg.coef_outer  <= COEF_OUTER_RST;
        end else if (w_write) begin
            unique case (w_idx)
                REG_FRAME_SIZE:  r_cfg.frame_size  <= pwdata[LEN_W-1:0];
                REG_COEF_INNER:  r_cfg.coef_inner  <= pwdata[COEF_W-1:0];
                REG_COEF_SECOND: r_cfg.coef_second <= pwdata[COEF_W-1:0];
                REG_COEF_THIRD:  r_cfg.coef_third  <= pwdata[COEF_W-1:0];
                REG_COEF_OUTER:  r_cfg.coef_outer  <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FRAME_SIZE:  prdata = PDATA_W'(r_cfg.frame_size);
            REG_COEF_INNER:  prdata = PDATA_W'($signed(r_cfg.coef_inner));
            REG_COEF_SECOND: prdata = PDATA_W'($signed(r_cfg.coef_second));
            REG_COEF_THIRD:  prdata = PDATA_W'($signed(r_cfg.coef_third));
            REG_COEF_OUTER:  prdata = PDATA_W'($signed(r_cfg.coef_outer));
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/spatial_derivative_fir_rectify.sv
// Top level of the spatial derivative filter with rectification.
`default_nettype none

// Streams the samples of one frame and applies the antisymmetric nine-tap
// derivative mask at every position, giving the plus result, its negation and
// the rectified sum. One sample is accepted per clock cycle while the input is
// not stalled. The result for position j leaves after sample j+4 has been
// accepted and has passed a four-register pipeline (difference, multiply,
// accumulate, result); the first result of an item shows once the item
// reaches the result register. Samples 0 to 3 of a frame produce no result
// unless one of them ends the frame; the final sample of a frame produces up
// to five results, delivered one per cycle from the result register while the
// output is not stalled. The input stalls only when the three stages behind
// the result register all hold items that cause results. The first and last
// four positions of a frame read as zero.
module spatial_derivative_fir_rectify
    import sdfr_pkg::*;
#(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_plus_value,
    output logic signed [OUT_W-1:0]    o_minus_value,
    output logic [OUT_W-1:0]           o_rectified_sum,
    output logic [POS_W-1:0]           o_position,
    output logic                       o_run_end,
    output logic                       o_frame_done
);

    localparam int PW = $clog2(MAX_SAMPLES);
    localparam int CW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

    typedef struct packed {
        logic             calc;
        logic             last;
        logic [CNT_W-1:0] count;
        logic [PW-1:0]    start;
    } t_ctrl;

    t_cfg w_cfg;

    sdfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input side: window, position counter and per-item control
    logic signed [SAMPLE_W-1:0] r_win [WIN_DEPTH];
    logic [PW-1:0]              r_in_pos;
    logic [PW-1:0]              n_in_pos;
    logic [CW-1:0]              w_len;
    logic [CW-1:0]              w_pos_ext;
    logic                       w_last;
    logic                       w_accept;
    t_ctrl                      w_ctrl;

    // Pipeline registers
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_run_valid;
    logic signed [DIFF_W-1:0]   r_diff [HALF_TAPS];
    logic signed [PROD_W-1:0]   r_prod [HALF_TAPS];
    t_ctrl                      r_ctrl1;
    t_ctrl                      r_ctrl2;
    t_ctrl                      r_ctrl3;
    t_ctrl                      r_run;
    logic signed [OUT_W-1:0]    r_plus3;
    logic signed [NEG_W-1:0]    r_minus3;
    logic signed [OUT_W-1:0]    r_run_plus;
    logic signed [OUT_W-1:0]    r_run_minus;
    logic [OUT_W-1:0]           r_run_rect;
    logic [CNT_W-1:0]           r_run_idx;

    logic                       w_free1;
    logic                       w_free2;
    logic                       w_free3;
    logic                       w_free4;
    logic                       w_take;
    logic                       w_run_end;

    logic signed [ACC_W-1:0]    w_acc;
    logic signed [OUT_W-1:0]    w_plus;
    logic signed [NEG_W-1:0]    w_minus;
    logic                       w_frac_zero;
    logic signed [MAG_W-1:0]    w_abs_minus;
    logic signed [RECT_W-1:0]   w_rect_pre;
    logic [OUT_W-1:0]           w_rect;
    logic                       w_calc_now;

    // A length of zero behaves as one, and lengths beyond the storage clamp.
    always_comb begin
        w_len = CW'(w_cfg.frame_size);
        if (w_len == '0) begin
            w_len = CW'(1);
        end else if (w_len > CW'(MAX_SAMPLES)) begin
            w_len = CW'(MAX_SAMPLES);
        end
    end

    assign w_pos_ext = CW'(r_in_pos);
    assign w_last    = (w_pos_ext + CW'(1)) >= w_len;
    assign n_in_pos  = w_last ? '0 : r_in_pos + PW'(1);

    // The item at position p completes position p-4; the final item of a
    // frame also flushes every position up to its own.
    always_comb begin
        w_ctrl.last  = w_last;
        w_ctrl.calc  = (r_in_pos >= PW'(CALC_FIRST)) && (w_pos_ext < w_len);
        w_ctrl.start = (r_in_pos >= PW'(HALF_TAPS)) ? r_in_pos - PW'(HALF_TAPS) : '0;
        if (w_last) begin
            w_ctrl.count = CNT_W'(r_in_pos - w_ctrl.start) + CNT_W'(1);
        end else begin
            w_ctrl.count = (r_in_pos >= PW'(HALF_TAPS)) ? CNT_W'(1) : '0;
        end
    end

    // Stall chain: a stage may load when it is empty or its item moves on.
    assign w_take    = r_run_valid && !i_out_stall;
    assign w_run_end = r_run_idx == (r_run.count - CNT_W'(1));
    assign w_free4   = !r_run_valid || (w_take && w_run_end);
    assign w_free3   = !r_v3 || w_free4;
    assign w_free2   = !r_v2 || w_free3;
    assign w_free1   = !r_v1 || w_free2;
    assign o_in_stall = !w_free1;
    assign w_accept  = i_in_valid && w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_idx   <= '0;
        end else begin
            if (w_accept) begin
                r_in_pos <= n_in_pos;
            end
            if (w_free1) begin
                r_v1 <= w_accept && (w_ctrl.count != '0);
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free3) begin
                r_v3 <= r_v2;
            end
            if (w_free4) begin
                r_run_valid <= r_v3;
                r_run_idx   <= '0;
            end else if (w_take) begin
                r_run_idx <= r_run_idx + CNT_W'(1);
            end
        end
    end

    // Window shift and differences of the mirrored taps.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0]  <= i_sample;
            r_diff[0] <= DIFF_W'(r_win[7]) - DIFF_W'(i_sample);
            r_diff[1] <= DIFF_W'(r_win[6]) - DIFF_W'(r_win[0]);
            r_diff[2] <= DIFF_W'(r_win[5]) - DIFF_W'(r_win[1]);
            r_diff[3] <= DIFF_W'(r_win[4]) - DIFF_W'(r_win[2]);
            r_ctrl1   <= w_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free2) begin
            r_prod[0] <= PROD_W'($signed(w_cfg.coef_outer)) * PROD_W'(r_diff[0]);
            r_prod[1] <= PROD_W'($signed(w_cfg.coef_third)) * PROD_W'(r_diff[1]);
            r_prod[2] <= PROD_W'($signed(w_cfg.coef_second)) * PROD_W'(r_diff[2]);
            r_prod[3] <= PROD_W'($signed(w_cfg.coef_inner)) * PROD_W'(r_diff[3]);
            r_ctrl2   <= r_ctrl1;
        end
    end

    // Taking the upper bits of the sum floors it; the negated mask floors
    // to one less than the negation whenever a fraction is dropped.
    assign w_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1])
                 + ACC_W'(r_prod[2]) + ACC_W'(r_prod[3]);
    assign w_plus      = w_acc[ACC_W-1:FRAC_W];
    assign w_frac_zero = (w_acc[FRAC_W-1:0] == '0);
    assign w_minus     = ~NEG_W'(w_plus) + NEG_W'(w_frac_zero);

    always_ff @(posedge i_clk) begin
        if (w_free3) begin
            r_plus3  <= w_plus;
            r_minus3 <= w_minus;
            r_ctrl3  <= r_ctrl2;
        end
    end

    assign w_abs_minus = r_minus3[NEG_W-1] ? -MAG_W'(r_minus3) : MAG_W'(r_minus3);
    assign w_rect_pre  = RECT_W'(r_plus3) + RECT_W'(w_abs_minus);
    assign w_rect      = OUT_W'(w_rect_pre[RECT_W-1] ? -w_rect_pre : w_rect_pre);

    always_ff @(posedge i_clk) begin
        if (w_free4) begin
            r_run_plus  <= r_plus3;
            r_run_minus <= OUT_W'(r_minus3);
            r_run_rect  <= w_rect;
            r_run       <= r_ctrl3;
        end
    end

    // Only the first result of a run can carry a computed value.
    assign w_calc_now      = r_run.calc && (r_run_idx == '0);
    assign o_out_valid     = r_run_valid;
    assign o_plus_value    = w_calc_now ? r_run_plus : '0;
    assign o_minus_value   = w_calc_now ? r_run_minus : '0;
    assign o_rectified_sum = w_calc_now ? r_run_rect : '0;
    assign o_position      = POS_W'(r_run.start + PW'(r_run_idx));
    assign o_run_end       = w_run_end;
    assign o_frame_done    = w_run_end && r_run.last;

`ifndef NO_ASSERTIONS
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_run.count != '0) && (r_run.count <= CNT_W'(MAX_RUN)))
        else $error("result run holds an impossible result count");

    a_run_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> r_run_idx < r_run.count)
        else $error("result index ran past the end of its run");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1 && r_v2 && r_v3 && r_run_valid)
        else $error("input stalled while the pipeline had a free stage");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_last |=> r_in_pos == '0)
        else $error("position counter did not wrap at the end of a frame");
`endif

endmodule

`default_nettype wire

### verif/tb_spatial_derivative_fir_rectify.sv
// Self-checking testbench of the spatial derivative filter with rectification.
`default_nettype none

module tb_spatial_derivative_fir_rectify
    import sdfr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME    = 256;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 120;
    localparam int REPORT_LIMIT = 30;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [OUT_W-1:0] plus_value;
        logic signed [OUT_W-1:0] minus_value;
        logic [OUT_W-1:0]        rectified_sum;
        logic [POS_W-1:0]        position;
        logic                    run_end;
        logic                    frame_done;
    } t_derivative;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [OUT_W-1:0]    o_plus_value;
    logic signed [OUT_W-1:0]    o_minus_value;
    logic [OUT_W-1:0]           o_rectified_sum;
    logic [POS_W-1:0]           o_position;
    logic                       o_run_end;
    logic                       o_frame_done;

    // Predictor state: register copies, sample window and frame counters.
    logic [LEN_W-1:0]           cfg_frame_size = FRAME_SIZE_RST;
    logic signed [COEF_W-1:0]   cfg_inner  = COEF_INNER_RST;
    logic signed [COEF_W-1:0]   cfg_second = COEF_SECOND_RST;
    logic signed [COEF_W-1:0]   cfg_third  = COEF_THIRD_RST;
    logic signed [COEF_W-1:0]   cfg_outer  = COEF_OUTER_RST;
    logic signed [SAMPLE_W-1:0] sample_history [WIN_DEPTH] = '{default: '0};
    int unsigned                frame_pos = 0;
    int unsigned                emit_pos = 0;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    t_derivative                expected_derivatives [$];
    int                         samples_sent = 0;
    int                         samples_taken = 0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;
    bit                         hold_receiver = 1'b0;
    bit                         pressure_armed = 1'b0;
    int                         mismatch_count = 0;
    t_derivative                seen_result;
    t_derivative                want_result;

    spatial_derivative_fir_rectify #(
        .MAX_SAMPLES(MAX_FRAME)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_plus_value(o_plus_value),
        .o_minus_value(o_minus_value),
        .o_rectified_sum(o_rectified_sum),
        .o_position(o_position),
        .o_run_end(o_run_end),
        .o_frame_done(o_frame_done)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Works out the results that one accepted sample causes and advances the
    // window and the frame counters.
    task automatic predict_derivatives(input logic signed [SAMPLE_W-1:0] x);
        int unsigned len;
        int unsigned stop;
        int unsigned centre;
        int unsigned pos;
        bit          last;
        bit          have_centre;
        bit          closes_run;
        longint      acc;
        longint      plus_v;
        longint      minus_v;
        longint      pv;
        longint      mv;
        longint      mag;
        int          n;
        t_derivative res;
        len = cfg_frame_size;
        if (len == 0) len = 1;
        if (len > MAX_FRAME) len = MAX_FRAME;
        last = (frame_pos + 1 >= len);
        have_centre = 1'b0;
        centre = 0;
        plus_v = 0;
        minus_v = 0;
        n = 0;
        if (frame_pos >= CALC_FIRST) begin
            acc = longint'(cfg_outer) * (longint'(sample_history[7]) - longint'(x))
                + longint'(cfg_third) * (longint'(sample_history[6]) - longint'(sample_history[0]))
                + longint'(cfg_second) * (longint'(sample_history[5]) - longint'(sample_history[1]))
                + longint'(cfg_inner) * (longint'(sample_history[4]) - longint'(sample_history[2]));
            centre = frame_pos - HALF_TAPS;
            if (centre + HALF_TAPS < len) begin
                plus_v = acc >>> 15;
                minus_v = (-acc) >>> 15;
                have_centre = 1'b1;
            end
        end
        if (last) stop = frame_pos + 1;
        else stop = (frame_pos >= HALF_TAPS) ? frame_pos - (HALF_TAPS - 1) : 0;
        for (pos = emit_pos; pos < stop && n < MAX_RUN; pos++) begin
            pv = (have_centre && pos == centre) ? plus_v : 0;
            mv = (have_centre && pos == centre) ? minus_v : 0;
            mag = (mv < 0) ? -mv : mv;
            mag = pv + mag;
            if (mag < 0) mag = -mag;
            closes_run = (pos + 1 == stop);
            res.plus_value = pv[OUT_W-1:0];
            res.minus_value = mv[OUT_W-1:0];
            res.rectified_sum = mag[OUT_W-1:0];
            res.position = pos[POS_W-1:0];
            res.run_end = closes_run;
            res.frame_done = last && closes_run;
            expected_derivatives.push_back(res);
            n++;
        end
        for (int i = WIN_DEPTH - 1; i > 0; i--) sample_history[i] = sample_history[i-1];
        sample_history[0] = x;
        if (last) begin
            frame_pos = 0;
            emit_pos = 0;
        end else begin
            frame_pos++;
            if (stop > emit_pos) emit_pos = stop;
        end
    endtask

    // Sender: offers the queued samples, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_derivatives(i_sample);
                samples_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_sample <= pending_samples.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_result.plus_value = o_plus_value;
                seen_result.minus_value = o_minus_value;
                seen_result.rectified_sum = o_rectified_sum;
                seen_result.position = o_position;
                seen_result.run_end = o_run_end;
                seen_result.frame_done = o_frame_done;
                if (expected_derivatives.size() == 0) begin
                    report_mismatch($sformatf("result at position %0d with none expected",
                                              o_position));
                end else begin
                    want_result = expected_derivatives.pop_front();
                    if (seen_result !== want_result) begin
                        report_mismatch($sformatf(
                            "got %0d/%0d/%0d pos %0d ends %b%b, expected %0d/%0d/%0d pos %0d ends %b%b",
                            seen_result.plus_value, seen_result.minus_value,
                            seen_result.rectified_sum, seen_result.position,
                            seen_result.run_end, seen_result.frame_done,
                            want_result.plus_value, want_result.minus_value,
                            want_result.rectified_sum, want_result.position,
                            want_result.run_end, want_result.frame_done));
                    end
                end
            end
            i_out_stall <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial begin
        wait (pressure_armed);
        @(posedge i_clk);
        hold_receiver <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_receiver <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_register(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_SIZE:  cfg_frame_size = value[LEN_W-1:0];
            REG_COEF_INNER:  cfg_inner = value[COEF_W-1:0];
            REG_COEF_SECOND: cfg_second = value[COEF_W-1:0];
            REG_COEF_THIRD:  cfg_third = value[COEF_W-1:0];
            REG_COEF_OUTER:  cfg_outer = value[COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int len, input logic signed [COEF_W-1:0] inner,
                                  input logic signed [COEF_W-1:0] second,
                                  input logic signed [COEF_W-1:0] third,
                                  input logic signed [COEF_W-1:0] outer);
        write_register(REG_FRAME_SIZE, 32'(len[LEN_W-1:0]));
        write_register(REG_COEF_INNER, 32'(inner));
        write_register(REG_COEF_SECOND, 32'(second));
        write_register(REG_COEF_THIRD, 32'(third));
        write_register(REG_COEF_OUTER, 32'(outer));
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] x);
        pending_samples.push_back(x);
        samples_sent++;
    endtask

    // Waits until every item has been taken and every result has arrived,
    // then lets items that cause no result clear the pipeline.
    task automatic settle();
        while (samples_taken != samples_sent || expected_derivatives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 16'(int'($urandom_range(16)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int seg;
        int len;
        int eff;
        int nsamp;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 27;
        recv_idle_pct <= 88;
        @(posedge i_clk);

        // Frames of one sample, with a length of one and of zero.
        write_register(REG_FRAME_SIZE, 32'd1);
        queue_sample(SAMPLE_MAX);
        settle();
        write_register(REG_FRAME_SIZE, 32'd0);
        queue_sample(SAMPLE_MIN);
        settle();

        // Short frame with extreme weights and samples for the largest output.
        apply_settings(12, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        for (int i = 0; i < 12; i++) begin
            if (i < 4 || i == 9) queue_sample(SAMPLE_MIN);
            else if (i == 4 || i == 10) queue_sample('0);
            else queue_sample(SAMPLE_MAX);
        end
        settle();

        // Oversized length, then the frame is cut short mid-way.
        apply_settings(511, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        repeat (7) queue_sample(random_sample());
        settle();
        write_register(REG_FRAME_SIZE, 32'd5);
        queue_sample(random_sample());
        settle();

        for (seg = 0; seg < 14; seg++) begin
            if (seg == 5) begin
                send_idle_pct <= 88;
                recv_idle_pct <= 27;
            end
            if (seg == 10) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                len = MAX_FRAME;
            end else begin
                case ($urandom_range(7))
                    0: len = $urandom_range(8);
                    1: len = $urandom_range(511, MAX_FRAME + 1);
                    default: len = $urandom_range(24, 9);
                endcase
            end
            apply_settings(len, random_coef(), random_coef(), random_coef(), random_coef());
            eff = (len == 0) ? 1 : ((len > MAX_FRAME) ? MAX_FRAME : len);
            if (len > MAX_FRAME) begin
                nsamp = $urandom_range(20, 5);
            end else begin
                nsamp = (frame_pos < eff) ? eff - int'(frame_pos) : 1;
                // Now and then leave a frame unfinished for the next setting.
                if ($urandom_range(2) == 0) nsamp += $urandom_range(8, 1);
            end
            if (seg == 10) pressure_armed = 1'b1;
            repeat (nsamp) queue_sample(random_sample());
            settle();
        end

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/core/sdfr_pkg.sv
rtl/core/sdfr_regs.sv
rtl/core/spatial_derivative_fir_rectify.sv
verif/tb_spatial_derivative_fir_rectify.sv
